/* sv/fcaf_pkg.sv */
// ----------------------------------------------------------------------------
// fcaf_pkg
// Shared widths, register indexes and reset values of the fire cross filter.
// ----------------------------------------------------------------------------
`default_nettype none

package fcaf_pkg;

  localparam int ROW_W      = 8;
  localparam int COL_OUT_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int DIM_W      = 9;
  localparam int CLAMP_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HEAT     = 2'd2;

  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 9'd80;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 9'd25;
  localparam logic [CLAMP_W-1:0] RST_MAX_HEAT     = 5'd23;

  localparam logic [DIM_W-1:0] MIN_DIM    = 9'd3;
  localparam logic [DIM_W-1:0] MAX_HEIGHT = 9'd256;

  // floor(x / 5) == (x * 205) >> 10 for x below 1024
  localparam int DIV5_MUL   = 205;
  localparam int DIV5_SHIFT = 10;

endpackage

`default_nettype wire

/* sv/fcaf_in_if.sv */
// ----------------------------------------------------------------------------
// fcaf_in_if
// Pixel channel: one heat value per beat, raster order.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcaf_in_if #(
  parameter int HEAT_BITS = 5
);
  logic                 valid;
  logic                 ready;
  logic [HEAT_BITS-1:0] heat_in;

  modport source (output valid, output heat_in, input ready);
  modport sink   (input valid, input heat_in, output ready);
endinterface

`default_nettype wire

/* sv/fcaf_out_if.sv */
// ----------------------------------------------------------------------------
// fcaf_out_if
// Result channel: destination position and averaged heat per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcaf_out_if
  import fcaf_pkg::*;
#(
  parameter int HEAT_BITS = 5
);
  logic                 valid;
  logic                 ready;
  logic [ROW_W-1:0]     out_row;
  logic [COL_OUT_W-1:0] out_col;
  logic [HEAT_BITS-1:0] out_heat;

  modport source (output valid, output out_row, output out_col, output out_heat,
                  input ready);
  modport sink   (input valid, input out_row, input out_col, input out_heat,
                  output ready);
endinterface

`default_nettype wire

/* sv/fire_cross_average_filter_unit.sv */
// ----------------------------------------------------------------------------
// fire_cross_average_filter_unit
// Five-point cross average over a raster heat stream, clamped to max_heat.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in takes one heat pixel per beat in raster order. For each pixel that
//   lies directly below an interior centre, one beat leaves on res_out with
//   the average of the centre and its four neighbours, tagged with the row
//   above the centre and the centre column. Border centres give no beat.
//   Throughput is one pixel per clock unless a held result stalls pix_in.
//   A result appears on res_out in the cycle after its pixel is taken. The
//   sums use two column-indexed line memories read ahead at the next column.
//   A single output register separates the channels: while a result waits,
//   a new pixel is still taken if res_out is ready in the same cycle, and
//   pix_in stalls only while the held result is not taken.
//   Reset (rst_ni low) clears the row and column counters and loads the
//   default frame size and clamp; line memory contents are not cleared, and no
//   result uses an entry that its frame has not yet written.
//   Configuration writes (cfg_we_i) are meant for idle periods only.
// ----------------------------------------------------------------------------
`default_nettype none

module fire_cross_average_filter_unit
  import fcaf_pkg::*;
#(
  parameter int MAX_WIDTH = 256,
  parameter int HEAT_BITS = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  fcaf_in_if.sink                    pix_in,
  fcaf_out_if.source                 res_out,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int SUMW = HEAT_BITS + 3;
  localparam int CMPW = (SUMW > 8) ? SUMW : 8;

  logic [DIM_W-1:0]   frame_width_q, frame_height_q;
  logic [CLAMP_W-1:0] max_heat_q;
  logic [CW-1:0]      col_q, col_d, col_r_addr;
  logic [ROW_W-1:0]   row_q, row_d;

  logic [HEAT_BITS-1:0] up_mem  [MAX_WIDTH];
  logic [HEAT_BITS-1:0] mid_mem [MAX_WIDTH];
  logic [HEAT_BITS-1:0] up_rd_q, mid_c_q, mid_r_q, left_q;

  logic                 out_valid_q;
  logic [ROW_W-1:0]     out_row_q;
  logic [COL_OUT_W-1:0] out_col_q;
  logic [HEAT_BITS-1:0] out_heat_q;

  logic                 in_acc, produce, col_wrap, row_wrap;
  logic [WW-1:0]        w_eff, col_ext, fw_ext;
  logic [DIM_W-1:0]     h_eff, row_ext;
  logic [CW:0]          col_nxt1;
  logic [SUMW-1:0]      sum;
  logic [CMPW-1:0]      sum_ext, thr;
  logic [15:0]          prod;
  logic [CLAMP_W-1:0]   quo, avg;

  assign pix_in.ready = ~out_valid_q | res_out.ready;
  assign in_acc       = pix_in.valid & pix_in.ready;

  // effective frame size
  always_comb begin
    fw_ext = WW'(frame_width_q);
    if (fw_ext < WW'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    if (frame_height_q < MIN_DIM) begin
      h_eff = MIN_DIM;
    end else if (frame_height_q > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = frame_height_q;
    end
  end

  assign col_ext  = WW'(col_q);
  assign row_ext  = DIM_W'(row_q);
  assign col_wrap = (col_ext + WW'(1)) >= w_eff;
  assign row_wrap = (row_ext + DIM_W'(1)) >= h_eff;
  assign produce  = (row_q >= ROW_W'(2)) && (row_ext < h_eff) &&
                    (col_q != '0) && ((col_ext + WW'(2)) <= w_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  assign col_nxt1   = {1'b0, col_d} + (CW+1)'(1);
  assign col_r_addr = (col_nxt1 >= (CW+1)'(MAX_WIDTH)) ? '0 : col_nxt1[CW-1:0];

  // five-point sum, clamp and divide by five
  assign sum = SUMW'(up_rd_q) + SUMW'(left_q) + SUMW'(mid_c_q) + SUMW'(mid_r_q)
             + SUMW'(pix_in.heat_in);
  assign sum_ext = CMPW'(sum);
  assign thr     = CMPW'({max_heat_q, 2'b00}) + CMPW'(max_heat_q) + CMPW'(5);
  assign prod    = 16'(sum_ext[7:0]) * 16'(DIV5_MUL);
  assign quo     = prod[DIV5_SHIFT +: CLAMP_W];
  assign avg     = (sum_ext >= thr) ? max_heat_q : quo;

  // line memories, read ahead at the next column
  always_ff @(posedge clk_i) begin
    up_rd_q <= up_mem[col_d];
    mid_c_q <= mid_mem[col_d];
    mid_r_q <= mid_mem[col_r_addr];
    if (in_acc) begin
      up_mem[col_q]  <= mid_c_q;
      mid_mem[col_q] <= pix_in.heat_in;
      left_q         <= mid_c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      max_heat_q     <= RST_MAX_HEAT;
      col_q          <= '0;
      row_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
          REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
          REG_MAX_HEAT:     max_heat_q     <= cfg_data_i[CLAMP_W-1:0];
          default: ;
        endcase
      end
      col_q <= col_d;
      row_q <= row_d;
      if (in_acc) begin
        out_valid_q <= produce;
      end else if (res_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && produce) begin
      out_row_q  <= row_q - ROW_W'(2);
      out_col_q  <= COL_OUT_W'(col_q);
      out_heat_q <= HEAT_BITS'(avg);
    end
  end

  assign res_out.valid    = out_valid_q;
  assign res_out.out_row  = out_row_q;
  assign res_out.out_col  = out_col_q;
  assign res_out.out_heat = out_heat_q;

endmodule

`default_nettype wire

/* bench/fire_cross_average_filter_unit_tb.sv */
// ----------------------------------------------------------------------------
// fire_cross_average_filter_unit_tb
// Self-checking bench for the five-point cross average filter. Pixel frames
// of many sizes are streamed in and each averaged beat is compared with a
// local prediction. The bench covers reset defaults, heat extremes and clamp,
// reconfiguration mid-frame, backpressure, size extremes and random frames.
// ----------------------------------------------------------------------------
`default_nettype none

module fire_cross_average_filter_unit_tb;
  import fcaf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH   = 256;
  localparam int HEAT_BITS   = 5;
  localparam int AVG_TAPS    = 5;
  localparam int CYCLE_LIMIT = 200_000;

  typedef logic [HEAT_BITS-1:0] heat_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    heat_t                heat;
  } avg_beat_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  fcaf_in_if  #(.HEAT_BITS(HEAT_BITS)) pix_if ();
  fcaf_out_if #(.HEAT_BITS(HEAT_BITS)) res_if ();

  fire_cross_average_filter_unit #(
    .MAX_WIDTH (MAX_WIDTH),
    .HEAT_BITS (HEAT_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_in     (pix_if.sink),
    .res_out    (res_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predicted filter state
  logic [DIM_W-1:0]   cfg_width  = RST_FRAME_WIDTH;
  logic [DIM_W-1:0]   cfg_height = RST_FRAME_HEIGHT;
  logic [CLAMP_W-1:0] cfg_clamp  = RST_MAX_HEAT;
  heat_t              above_line  [MAX_WIDTH];
  heat_t              centre_line [MAX_WIDTH];
  int unsigned        row_pos = 0;
  int unsigned        col_pos = 0;

  avg_beat_t expected_avg_q[$];
  avg_beat_t head_beat;

  int fail_count   = 0;
  int pixels_sent  = 0;
  int src_idle_pct = 33;
  int snk_idle_pct = 57;
  int hold_left    = 0;
  int cycle_count  = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned sat_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v < MIN_DIM) return 32'(MIN_DIM);
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic int frame_pixels();
    return sat_dim(cfg_width, MAX_WIDTH) * sat_dim(cfg_height, 32'(MAX_HEIGHT));
  endfunction

  task automatic predict_cross_average(input heat_t heat);
    int unsigned w, h, c, r, total;
    avg_beat_t   beat;
    w = sat_dim(cfg_width, MAX_WIDTH);
    h = sat_dim(cfg_height, 32'(MAX_HEIGHT));
    c = col_pos;
    r = row_pos;
    if (r >= 2 && r < h && c >= 1 && c + 2 <= w && c + 1 < MAX_WIDTH) begin
      total = 32'(above_line[c]) + 32'(above_line[c-1]) + 32'(centre_line[c])
            + 32'(centre_line[c+1]) + 32'(heat);
      total = total / AVG_TAPS;
      if (total > 32'(cfg_clamp)) total = 32'(cfg_clamp);
      beat.row  = ROW_W'(r - 2);
      beat.col  = COL_OUT_W'(c);
      beat.heat = heat_t'(total);
      expected_avg_q.push_back(beat);
    end
    if (c < MAX_WIDTH) begin
      above_line[c]  = centre_line[c];
      centre_line[c] = heat;
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // one beat per pixel, random heat in [lo, hi]
  task automatic send_pixels(input int count, input int lo, input int hi);
    heat_t heat;
    repeat (count) begin
      heat = heat_t'($urandom_range(hi, lo));
      if ($urandom_range(99) < src_idle_pct) begin
        pix_if.valid <= 1'b0;
        repeat ($urandom_range(3, 1)) @(posedge clk_i);
      end
      pix_if.valid   <= 1'b1;
      pix_if.heat_in <= heat;
      do @(posedge clk_i); while (!(pix_if.valid && pix_if.ready));
      predict_cross_average(heat);
      pixels_sent++;
    end
  endtask

  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_avg_q.size() != 0) @(posedge clk_i);
    // border pixels give no beat but may still be in flight
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  cfg_width = data;
      REG_FRAME_HEIGHT: cfg_height = data;
      REG_MAX_HEAT:     cfg_clamp = data[CLAMP_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_frame(input int w, input int h, input int clamp);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_MAX_HEAT, CFG_DATA_W'(clamp));
  endtask

  // default width and clamp on three rows, then the rest of a default-height frame
  task automatic test_reset_values();
    send_pixels(3 * int'(RST_FRAME_WIDTH), 16, 31);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
    send_pixels(3 * (int'(RST_FRAME_HEIGHT) - 3), 0, 31);
  endtask

  task automatic test_heat_extremes();
    set_frame(3, 3, 31);
    send_pixels(9, 31, 31);
    send_pixels(9, 0, 0);
    wait_drained();
    write_reg(REG_MAX_HEAT, CFG_DATA_W'(0));
    send_pixels(9, 31, 31);
  endtask

  // counters past a shrunk bound must wrap at the end of the step
  task automatic test_midframe_reconfig();
    set_frame(8, 6, 31);
    send_pixels(8 * 3 + 5, 0, 31);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(4));
    send_pixels(1 + 4 + 2, 0, 31);
    wait_drained();
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(4));
    send_pixels(2, 0, 31);
  endtask

  task automatic test_backpressure();
    set_frame(10, 6, 31);
    hold_left = 150;
    send_pixels(frame_pixels(), 0, 31);
    wait_drained();
  endtask

  // full-width rows, then a tall frame entered mid-row
  task automatic test_size_extremes();
    set_frame(511, 3, 31);
    send_pixels(2 * MAX_WIDTH + 16, 0, 31);
    set_frame(0, 511, 19);
    send_pixels(24, 8, 31);
  endtask

  task automatic test_random_stream(input int src_pct, input int snk_pct, input int count);
    int target, w, h, clamp;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    target = pixels_sent + count;
    while (pixels_sent < target) begin
      w     = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(12, 3);
      h     = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
      clamp = $urandom_range(1) ? 31 : $urandom_range(31);
      set_frame(w, h, clamp);
      if ($urandom_range(2) == 0) send_pixels(frame_pixels() * $urandom_range(2, 1), 20, 31);
      else send_pixels(frame_pixels() * $urandom_range(2, 1), 0, 31);
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_data_i     <= '0;
    pix_if.valid   <= 1'b0;
    pix_if.heat_in <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_heat_extremes();
    test_midframe_reconfig();
    test_backpressure();
    test_size_extremes();
    test_random_stream(33, 57, 30);
    test_random_stream(57, 33, 30);
    test_random_stream(0, 0, 30);
    wait_drained();
    if (fail_count == 0 && expected_avg_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_avg_q.size() == 0) begin
        $error("unexpected beat: out_row %0d out_col %0d out_heat %0d",
               res_if.out_row, res_if.out_col, res_if.out_heat);
        fail_count++;
      end else begin
        head_beat = expected_avg_q.pop_front();
        if (res_if.out_row !== head_beat.row) begin
          $error("out_row: expected %0d, actual %0d", head_beat.row, res_if.out_row);
          fail_count++;
        end
        if (res_if.out_col !== head_beat.col) begin
          $error("out_col: expected %0d, actual %0d", head_beat.col, res_if.out_col);
          fail_count++;
        end
        if (res_if.out_heat !== head_beat.heat) begin
          $error("out_heat: expected %0d, actual %0d", head_beat.heat, res_if.out_heat);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
sv/fcaf_pkg.sv
sv/fcaf_in_if.sv
sv/fcaf_out_if.sv
sv/fire_cross_average_filter_unit.sv
bench/fire_cross_average_filter_unit_tb.sv
